### hdl/assert_macros.svh
// Assertion macros used by the SM3 back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds on every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that ante at one edge implies cons at the next.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/sm3_pkg.sv
// Shared types and constants for the SM3 engine.
package sm3_pkg;
	localparam logic [31:0] T_LOW  = 32'h79CC4519;
	localparam logic [31:0] T_HIGH = 32'h7A879D8A;
	localparam logic [255:0] SM3_IV =
		256'h7380166F4914B2B9172442D7DA8A0600A96F30BC163138AAE38DEE4DB0FB0E4E;
	localparam int QDEPTH = 4;

	// Classified beat passed from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
	} sm3_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_LEN, ST_COMP, ST_OUT
	} sm3_state_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] p0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] p1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction
endpackage

### hdl/sm3_front.sv
// Input front: accepts beats, drops idle ones, queues the rest.
module sm3_front import sm3_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] msg_byte,
	input  logic       byte_valid,
	input  logic       last_byte,
	output logic       q_avail,
	output sm3_beat_t  q_beat,
	input  logic       q_take
);
	localparam int AW = $clog2(QDEPTH);
	sm3_beat_t         mem_q [QDEPTH];
	logic [AW-1:0]     wp_q, rp_q;
	logic [AW:0]       cnt_q;
	logic              wr;

	assign full    = (cnt_q == (AW+1)'(QDEPTH));
	assign wr      = push && !full && (byte_valid || last_byte);
	assign q_avail = (cnt_q != '0);
	assign q_beat  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= '{data: msg_byte, valid: byte_valid, last: last_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (q_take) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(q_take);
		end
	end
endmodule

### hdl/sm3_back.sv
// Back end: block packing, padding, 64-round compression and digest output.
module sm3_back import sm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_avail,
	input  sm3_beat_t   q_beat,
	output logic        q_take,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	`include "assert_macros.svh"

	sm3_state_t  state_q, state_d;
	logic [31:0] cv_q [8];
	logic [31:0] buf_q [16];
	logic [31:0] w_q [16];
	logic [31:0] r_q [8];
	logic [63:0] bits_q, len_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [2:0]  lcnt_q;
	logic [2:0]  oidx_q;
	logic        fin_q;
	sm3_state_t  ret_q;

	// byte source for the packer
	logic        put;
	logic [7:0]  pbyte;
	logic        blk_done;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (q_avail) begin
				if (q_beat.valid && fill_q == 6'd63) state_d = ST_COMP;
				else if (q_beat.last) state_d = ST_PAD;
			end
			ST_PAD:  if (fill_q == 6'd63) state_d = ST_COMP;
				else if (fill_q == 6'd55 || (fill_q == 6'd56 && fin_q)) state_d = ST_LEN;
			ST_LEN:  if (fill_q == 6'd63) state_d = ST_COMP;
			ST_COMP: if (rnd_q == 6'd63) state_d = ret_q;
			ST_OUT:  if (pop && oidx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_take = (state_q == ST_IDLE) && q_avail;
		put    = 1'b0;
		pbyte  = 8'h00;
		case (state_q)
			ST_IDLE: begin put = q_take && q_beat.valid; pbyte = q_beat.data; end
			ST_PAD:  begin put = 1'b1; pbyte = fin_q ? 8'h00 : 8'h80; end
			ST_LEN:  begin put = 1'b1; pbyte = len_q[63 - 8*lcnt_q -: 8]; end
			default: ;
		endcase
	end
	assign blk_done    = put && fill_q == 6'd63;
	assign empty       = (state_q != ST_OUT);
	assign digest_word = cv_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

	// round datapath
	logic [31:0] wnew, wj, wj4, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
	always_comb begin
		wnew = p1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
		wj   = w_q[0];
		wj4  = w_q[4];
		tj   = (rnd_q < 6'd16) ? T_LOW : T_HIGH;
		a12  = rotl(r_q[0], 5'd12);
		ss1  = rotl(a12 + r_q[4] + rotl(tj, rnd_q[4:0]), 5'd7);
		ss2  = ss1 ^ a12;
		if (rnd_q < 6'd16) begin
			ff = r_q[0] ^ r_q[1] ^ r_q[2];
			gg = r_q[4] ^ r_q[5] ^ r_q[6];
		end else begin
			ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
			gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
		end
		tt1 = ff + r_q[3] + ss2 + (wj ^ wj4);
		tt2 = gg + r_q[7] + ss1 + wj;
	end

	always_ff @(posedge clk) begin
		if (put) begin
			if (fill_q[1:0] == 2'd0) buf_q[fill_q[5:2]] <= {pbyte, 24'h0};
			else buf_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= pbyte;
		end
		if (blk_done) begin
			// load schedule window with the finished block
			for (int k = 0; k < 15; k++) w_q[k] <= buf_q[k];
			w_q[15] <= {buf_q[15][31:8], pbyte};
			for (int k = 0; k < 8; k++) r_q[k] <= cv_q[k];
		end else if (state_q == ST_COMP) begin
			for (int k = 0; k < 15; k++) w_q[k] <= w_q[k+1];
			w_q[15] <= wnew;
			r_q[3] <= r_q[2];
			r_q[2] <= rotl(r_q[1], 5'd9);
			r_q[1] <= r_q[0];
			r_q[0] <= tt1;
			r_q[7] <= r_q[6];
			r_q[6] <= rotl(r_q[5], 5'd19);
			r_q[5] <= r_q[4];
			r_q[4] <= p0(tt2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			for (int k = 0; k < 8; k++) cv_q[k] <= SM3_IV[255 - 32*k -: 32];
			bits_q  <= '0;
			len_q   <= '0;
			fill_q  <= '0;
			rnd_q   <= '0;
			lcnt_q  <= '0;
			oidx_q  <= '0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (put) fill_q <= fill_q + 6'd1;
			if (state_q == ST_IDLE && q_take) begin
				if (q_beat.valid) bits_q <= bits_q + 64'd8;
				len_q <= bits_q + (q_beat.valid ? 64'd8 : 64'd0);
				fin_q <= 1'b0;
				lcnt_q <= '0;
				ret_q <= q_beat.last ? ST_PAD : ST_IDLE;
			end
			if (state_q == ST_PAD) begin
				fin_q <= 1'b1;
				if (fill_q == 6'd63) ret_q <= ST_PAD;
				if (fill_q == 6'd55 || (fill_q == 6'd56 && fin_q)) ret_q <= ST_OUT;
			end
			if (state_q == ST_LEN) begin
				lcnt_q <= lcnt_q + 3'd1;
				ret_q  <= ST_OUT;
			end
			if (state_q == ST_COMP) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					cv_q[0] <= cv_q[0] ^ tt1;
					cv_q[1] <= cv_q[1] ^ r_q[0];
					cv_q[2] <= cv_q[2] ^ rotl(r_q[1], 5'd9);
					cv_q[3] <= cv_q[3] ^ r_q[2];
					cv_q[4] <= cv_q[4] ^ p0(tt2);
					cv_q[5] <= cv_q[5] ^ r_q[4];
					cv_q[6] <= cv_q[6] ^ rotl(r_q[5], 5'd19);
					cv_q[7] <= cv_q[7] ^ r_q[6];
				end
			end
			if (state_q == ST_OUT && pop) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7) begin
					for (int k = 0; k < 8; k++) cv_q[k] <= SM3_IV[255 - 32*k -: 32];
					bits_q <= '0;
					fill_q <= '0;
				end
			end
		end
	end

	`CHK_ALWAYS(a_take_idle, clk, arst_n, !q_take || state_q == ST_IDLE, "take outside idle")
	`CHK_NEXT(a_comp_start, clk, arst_n, blk_done, state_q == ST_COMP && rnd_q == 6'd0, "no compress after block")
	`CHK_ALWAYS(a_out_fill, clk, arst_n, state_q != ST_OUT || fill_q == 6'd0, "digest with partial block")
endmodule

### hdl/sm3_hash_engine.sv
// SM3 engine: bytes are packed into a block while the core is idle; each block is compressed in 64 rounds.
// No byte is taken during compression; the 64th byte of a block starts the rounds.
// On a last beat, padding writes the pad bytes and adds one or two compressions,
// then eight digest beats are offered. A four-entry queue decouples input from the core.
// Asynchronous active-low reset returns the chain to the IV and empties the queue.
module sm3_hash_engine import sm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  msg_byte,
	input  logic        byte_valid,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	logic      q_avail, q_take;
	sm3_beat_t q_beat;

	sm3_front u_front (
		.clk, .arst_n, .push, .full, .msg_byte, .byte_valid, .last_byte,
		.q_avail, .q_beat, .q_take
	);

	sm3_back u_back (
		.clk, .arst_n, .q_avail, .q_beat, .q_take,
		.empty, .pop, .digest_word, .word_index, .last_word
	);
endmodule
